/* sv/b64_pkg.sv */
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and alphabet helpers for the Base64 stream codec.
// ----------------------------------------------------------------------------
package b64_pkg;

  // Default depth of the job queue between front and back
  localparam int JOB_FIFO_DEPTH = 2;

  // Padding character '='
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Register index of decode_mode (paddr[2])
  localparam logic CFG_IDX_MODE = 1'b0;

  // Input transaction payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_item;
  } in_item_t;

  // Result transaction payload
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       bad_input;
  } out_item_t;

  // One finished group, handed from front to back
  typedef struct packed {
    logic [23:0] bits;    // gathered 24-bit group
    logic        dec;     // 1: results are bytes, 0: results are characters
    logic [1:0]  cnt_m1;  // number of results minus one
    logic [1:0]  pads;    // trailing '=' characters (encode)
    logic        last;    // group closes the message
    logic        bad;     // flag for every result of the group
  } job_t;

  // 6-bit value to alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26)      enc_char = 8'h41 + w;
    else if (v < 6'd52) enc_char = 8'h61 + w - 8'd26;
    else if (v < 6'd62) enc_char = 8'h30 + w - 8'd52;
    else if (v == 6'd62) enc_char = 8'h2B;
    else                 enc_char = 8'h2F;
  endfunction

  // Alphabet character to {valid, 6-bit value}
  function automatic logic [6:0] dec_char(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    dec_char = 7'h00;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'h41;
      dec_char = {1'b1, t[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'h61 + 8'd26;
      dec_char = {1'b1, t[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30 + 8'd52;
      dec_char = {1'b1, t[5:0]};
    end else if (c == 8'h2B) begin
      dec_char = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      dec_char = {1'b1, 6'd63};
    end
  endfunction

  // Padding for a final encode group holding 'filled' bytes
  function automatic logic [1:0] pad_count(input logic [1:0] filled);
    case (filled)
      2'd1:    pad_count = 2'd2;
      2'd2:    pad_count = 2'd1;
      default: pad_count = 2'd0;
    endcase
  endfunction

endpackage

/* sv/b64_front.sv */
// ----------------------------------------------------------------------------
// b64_front
// Accepts bytes or characters, gathers groups and issues one job per group.
// ----------------------------------------------------------------------------
module b64_front
  import b64_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     clr,          // register write: drop the partial group
  input  logic     decode_mode,
  input  logic     in_take,      // input transaction accepted this cycle
  input  in_item_t in_item,
  output logic     job_push,
  output job_t     job
);

  logic [23:0] group_bits_r, group_bits_nxt;
  logic [1:0]  group_pos_r, group_pos_nxt;
  logic        third_pad_r, third_pad_nxt;
  logic        bad_seen_r, bad_seen_nxt;

  logic [7:0]  b;
  logic        lst;
  logic [6:0]  dc;
  logic        is_pad;
  logic        bad_cur;
  logic        bad_now;
  logic [5:0]  v6;
  logic [23:0] dec_bits;
  logic [23:0] enc_bits;
  logic [1:0]  filled;
  logic [1:0]  pad_sub;

  // classify the incoming item
  always_comb begin
    b       = in_item.data_byte;
    lst     = in_item.last_item;
    dc      = dec_char(b);
    is_pad  = (b == PAD_CHAR);
    bad_cur = !is_pad && !dc[6];
    bad_now = bad_seen_r | bad_cur;
    v6      = (is_pad || !dc[6]) ? 6'd0 : dc[5:0];
    filled  = group_pos_r + 2'd1;
    pad_sub = {1'b0, lst & is_pad} + {1'b0, lst & third_pad_r};
  end

  // place the new sextet or byte into the group
  always_comb begin
    case (group_pos_r)
      2'd0:    dec_bits = group_bits_r | {v6, 18'd0};
      2'd1:    dec_bits = group_bits_r | {6'd0, v6, 12'd0};
      2'd2:    dec_bits = group_bits_r | {12'd0, v6, 6'd0};
      default: dec_bits = group_bits_r | {18'd0, v6};
    endcase
    case (group_pos_r)
      2'd0:    enc_bits = group_bits_r | {b, 16'd0};
      2'd1:    enc_bits = group_bits_r | {8'd0, b, 8'd0};
      default: enc_bits = group_bits_r | {16'd0, b};
    endcase
  end

  // group state update and job issue
  always_comb begin
    group_bits_nxt = group_bits_r;
    group_pos_nxt  = group_pos_r;
    third_pad_nxt  = third_pad_r;
    bad_seen_nxt   = bad_seen_r;
    job_push       = 1'b0;
    job            = '0;
    if (clr) begin
      group_bits_nxt = '0;
      group_pos_nxt  = '0;
      third_pad_nxt  = 1'b0;
      bad_seen_nxt   = 1'b0;
    end else if (in_take) begin
      if (decode_mode) begin
        if (group_pos_r != 2'd3) begin
          if (lst) begin
            // incomplete final group: one flagged zero byte
            job_push       = 1'b1;
            job.dec        = 1'b1;
            job.last       = 1'b1;
            job.bad        = 1'b1;
            group_bits_nxt = '0;
            group_pos_nxt  = '0;
            third_pad_nxt  = 1'b0;
            bad_seen_nxt   = 1'b0;
          end else begin
            group_bits_nxt = dec_bits;
            group_pos_nxt  = filled;
            bad_seen_nxt   = bad_now;
            if (group_pos_r == 2'd2) third_pad_nxt = is_pad;
          end
        end else begin
          job_push       = 1'b1;
          job.bits       = dec_bits;
          job.dec        = 1'b1;
          job.cnt_m1     = 2'd2 - pad_sub;
          job.last       = lst;
          job.bad        = bad_now;
          group_bits_nxt = '0;
          group_pos_nxt  = '0;
          third_pad_nxt  = 1'b0;
          bad_seen_nxt   = lst ? 1'b0 : bad_now;
        end
      end else begin
        if (filled == 2'd3 || lst) begin
          job_push       = 1'b1;
          job.bits       = enc_bits;
          job.cnt_m1     = 2'd3;
          job.pads       = pad_count(filled);
          job.last       = lst;
          group_bits_nxt = '0;
          group_pos_nxt  = '0;
          third_pad_nxt  = 1'b0;
          bad_seen_nxt   = 1'b0;
        end else begin
          group_bits_nxt = enc_bits;
          group_pos_nxt  = filled;
        end
      end
    end
  end

  // group state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_bits_r <= '0;
      group_pos_r  <= '0;
      third_pad_r  <= 1'b0;
      bad_seen_r   <= 1'b0;
    end else begin
      group_bits_r <= group_bits_nxt;
      group_pos_r  <= group_pos_nxt;
      third_pad_r  <= third_pad_nxt;
      bad_seen_r   <= bad_seen_nxt;
    end
  end

endmodule

/* sv/b64_job_fifo.sv */
// ----------------------------------------------------------------------------
// b64_job_fifo
// Short queue of group jobs between the front and the back.
// ----------------------------------------------------------------------------
module b64_job_fifo
  import b64_pkg::*;
#(
  parameter int DEPTH = JOB_FIFO_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  job_t wr_job,
  input  logic rd_en,
  output job_t rd_job,
  output logic q_full,
  output logic q_empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr, do_rd;

  assign q_full  = (cnt_r == FULL_CNT);
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_job  = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_job;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      if (do_wr && !do_rd)      cnt_r <= cnt_r + 1'b1;
      else if (do_rd && !do_wr) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

/* sv/b64_back.sv */
// ----------------------------------------------------------------------------
// b64_back
// Expands jobs into output register results, one per cycle unless pop stalls.
// ----------------------------------------------------------------------------
module b64_back
  import b64_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      head,
  input  logic      head_empty,
  output logic      head_pop,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_data
);

  logic [1:0] k_r;
  logic       out_valid_r;
  out_item_t  out_item_r;

  logic       ld;
  logic [2:0] pad_pos;
  logic [5:0] sext;
  logic [7:0] dbyte;
  out_item_t  res;

  assign ld       = !head_empty && (!out_valid_r || pop);
  assign head_pop = ld && (k_r == head.cnt_m1);
  assign empty    = !out_valid_r;
  assign out_data = out_item_r;

  // select the k-th sextet or byte of the group
  always_comb begin
    case (k_r)
      2'd0:    sext = head.bits[23:18];
      2'd1:    sext = head.bits[17:12];
      2'd2:    sext = head.bits[11:6];
      default: sext = head.bits[5:0];
    endcase
    case (k_r)
      2'd0:    dbyte = head.bits[23:16];
      2'd1:    dbyte = head.bits[15:8];
      default: dbyte = head.bits[7:0];
    endcase
    pad_pos = {1'b0, k_r} + {1'b0, head.pads};
  end

  // build the result
  always_comb begin
    if (head.dec)                res.out_byte = dbyte;
    else if (pad_pos >= 3'd4)    res.out_byte = PAD_CHAR;
    else                         res.out_byte = enc_char(sext);
    res.out_last  = head.last && (k_r == head.cnt_m1);
    res.bad_input = head.bad;
  end

  // output register
  always_ff @(posedge clk) begin
    if (ld) out_item_r <= res;
  end

  // result index and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld) k_r <= head_pop ? 2'd0 : k_r + 2'd1;
      if (ld)       out_valid_r <= 1'b1;
      else if (pop) out_valid_r <= 1'b0;
    end
  end

endmodule

/* sv/base64_stream_codec_top.sv */
// ----------------------------------------------------------------------------
// base64_stream_codec_top
// Streaming Base64 encoder/decoder, standard alphabet, mode set by register.
// ----------------------------------------------------------------------------
//  channel  | handshake                     | payload
//  ---------+-------------------------------+--------------------------------
//  input    | push / full                   | in_data  (data_byte, last_item)
//  result   | pop / empty                   | out_data (out_byte, out_last,
//           |                               |           bad_input)
//  config   | psel penable pwrite pready    | paddr, pwdata, prdata
//
//  The front takes one item per cycle while the job queue has room; a group
//  that completes is queued in the same cycle. The back issues one result per
//  cycle from the queue head while results are popped, so encoding sustains
//  4 results per 3 bytes, decoding one character per cycle. The item closing
//  a group is written to the job queue, then loaded into the output register.
//  Synchronous active-low reset; no clearing pass. A stalled pop holds the
//  output register while the front keeps filling the queue.
// ----------------------------------------------------------------------------
module base64_stream_codec_top
  import b64_pkg::*;
#(
  parameter int FIFO_DEPTH = JOB_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        push,
  output logic        full,
  input  in_item_t    in_data,
  // result channel
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_data,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic decode_mode_r;
  logic cfg_wr;
  logic in_take;
  logic job_push;
  job_t job;
  job_t head;
  logic q_full, q_empty, head_pop;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_MODE);
  assign prdata = (paddr[2] == CFG_IDX_MODE) ? {31'd0, decode_mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n)      decode_mode_r <= 1'b0;
    else if (cfg_wr) decode_mode_r <= pwdata[0];
  end

  // input transaction
  assign full    = q_full;
  assign in_take = push && !full;

  b64_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .clr         (cfg_wr),
    .decode_mode (decode_mode_r),
    .in_take     (in_take),
    .in_item     (in_data),
    .job_push    (job_push),
    .job         (job)
  );

  b64_job_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_job  (job),
    .rd_en   (head_pop),
    .rd_job  (head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  b64_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_empty (q_empty),
    .head_pop   (head_pop),
    .pop        (pop),
    .empty      (empty),
    .out_data   (out_data)
  );

endmodule
